// File: design/hilb3_pkg.sv
// shared types, constants and bit-level helpers for the 3-d hilbert index converter
// no dependencies; imported by every module of the block
package hilb3_pkg;

   localparam int AXIS_BITS  = 8;
   localparam int INDEX_BITS = 3 * AXIS_BITS;
   localparam int NUM_LEVELS = AXIS_BITS - 1;

   localparam logic MODE_ENCODE = 1'b0;
   localparam logic MODE_DECODE = 1'b1;

   typedef logic [AXIS_BITS-1:0]  axis_type;
   typedef logic [INDEX_BITS-1:0] index_type;
   typedef axis_type [2:0]        axis3_type;

   typedef struct packed {
      logic      mode;
      axis_type  coord_x;
      axis_type  coord_y;
      axis_type  coord_z;
      index_type curve_index;
   } req_type;

   typedef struct packed {
      index_type index_out;
      axis_type  x_out;
      axis_type  y_out;
      axis_type  z_out;
   } rsp_type;

   // what travels between the pipeline stages
   typedef struct packed {
      logic      mode;
      axis3_type v;
   } pipe_type;

   // one exchange-or-invert step on axis i at bit q
   function automatic axis3_type swap_step(axis3_type v, logic [1:0] i, axis_type q);
      axis3_type r;
      axis_type  p;
      axis_type  t;
      r = v;
      p = q - axis_type'(1);
      if ((r[i] & q) != '0) begin
         r[0] = r[0] ^ p;
      end else begin
         t    = (r[0] ^ r[i]) & p;
         r[0] = r[0] ^ t;
         r[i] = r[i] ^ t;
      end
      return r;
   endfunction

endpackage

// File: design/hilb3_front.sv
// input stage: de-interleaves and gray-decodes an index, or passes coordinates
// depends on hilb3_pkg
module hilb3_front import hilb3_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     load,
   input  logic     valid_in,
   input  req_type  req_in,
   output logic     valid_out,
   output pipe_type data_out
);

   logic     valid_ff;
   pipe_type data_ff;
   pipe_type data_in;
   axis3_type dv;
   axis_type  t;

   always_comb begin
      for (int k = 0; k < AXIS_BITS; k++) begin
         dv[0][k] = req_in.curve_index[3*k+2];
         dv[1][k] = req_in.curve_index[3*k+1];
         dv[2][k] = req_in.curve_index[3*k];
      end
      // gray decode across the three axis words
      t     = dv[2] >> 1;
      dv[2] = dv[2] ^ dv[1];
      dv[1] = dv[1] ^ dv[0];
      dv[0] = dv[0] ^ t;

      data_in.mode = req_in.mode;
      if (req_in.mode == MODE_DECODE) begin
         data_in.v = dv;
      end else begin
         data_in.v[0] = req_in.coord_x;
         data_in.v[1] = req_in.coord_y;
         data_in.v[2] = req_in.coord_z;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (load) begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= data_in;
      end
   end

   assign valid_out = valid_ff;
   assign data_out  = data_ff;

endmodule

// File: design/hilb3_level.sv
// one bit level of the exchange/invert network, encode or decode per beat
// depends on hilb3_pkg; the level's bit masks come in as constant ports
module hilb3_level import hilb3_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     load,
   input  axis_type enc_q,
   input  axis_type dec_q,
   input  logic     valid_in,
   input  pipe_type data_in,
   output logic     valid_out,
   output pipe_type data_out
);

   logic      valid_ff;
   pipe_type  data_ff;
   pipe_type  next_in;
   axis3_type enc_v;
   axis3_type dec_v;

   always_comb begin
      // encode walks axes 0..2, decode walks them 2..0
      enc_v = swap_step(swap_step(swap_step(data_in.v, 2'd0, enc_q), 2'd1, enc_q),
                        2'd2, enc_q);
      dec_v = swap_step(swap_step(swap_step(data_in.v, 2'd2, dec_q), 2'd1, dec_q),
                        2'd0, dec_q);
      next_in.mode = data_in.mode;
      next_in.v    = (data_in.mode == MODE_DECODE) ? dec_v : enc_v;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (load) begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= next_in;
      end
   end

   assign valid_out = valid_ff;
   assign data_out  = data_ff;

endmodule

// File: design/hilb3_back.sv
// output stage: gray-encodes and interleaves the index, or hands out coordinates
// depends on hilb3_pkg
module hilb3_back import hilb3_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     load,
   input  logic     valid_in,
   input  pipe_type data_in,
   output logic     valid_out,
   output rsp_type  rsp_out
);

   logic      valid_ff;
   rsp_type   rsp_ff;
   rsp_type   rsp_in;
   axis3_type ev;
   axis_type  t;

   always_comb begin
      ev    = data_in.v;
      ev[1] = ev[1] ^ ev[0];
      ev[2] = ev[2] ^ ev[1];
      // bit j flips when an odd number of higher bits of the last word are set
      t = '0;
      for (int j = 0; j < AXIS_BITS - 1; j++) begin
         t[j] = ^(ev[2] >> (j + 1));
      end
      ev[0] = ev[0] ^ t;
      ev[1] = ev[1] ^ t;
      ev[2] = ev[2] ^ t;

      rsp_in = '0;
      if (data_in.mode == MODE_DECODE) begin
         rsp_in.x_out = data_in.v[0];
         rsp_in.y_out = data_in.v[1];
         rsp_in.z_out = data_in.v[2];
      end else begin
         for (int k = 0; k < AXIS_BITS; k++) begin
            rsp_in.index_out[3*k+2] = ev[0][k];
            rsp_in.index_out[3*k+1] = ev[1][k];
            rsp_in.index_out[3*k]   = ev[2][k];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (load) begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         rsp_ff <= rsp_in;
      end
   end

   assign valid_out = valid_ff;
   assign rsp_out   = rsp_ff;

endmodule

// File: design/hilbert_3d_index_convert.sv
// top level of the 3-d hilbert index converter: front stage, one stage per bit level,
// output stage; depends on hilb3_pkg, hilb3_front, hilb3_level and hilb3_back
//
// Usage:
//  - req channel (req_valid, req_stall, req_data) takes one beat per conversion;
//    req_data.mode picks coordinates-to-index or index-to-coordinates.
//  - rsp channel (rsp_valid, rsp_stall, rsp_data) returns one beat per request,
//    in order; the fields the mode does not produce are zero.
//  - pipeline: nine register stages (one front stage, seven bit-level stages, one
//    output stage, i.e. bit width plus one); a request passes the front, bit-level
//    and output registers in that order before rsp_valid rises for it.
//  - throughput: one beat per cycle unless rsp stalls; each bit level owns its stage.
//  - a stall on rsp holds the output register; stages behind it keep filling
//    empty slots, so req_stall rises only once every stage holds a beat.
//  - reset (synchronous) empties the pipeline; no state survives between beats.
module hilbert_3d_index_convert import hilb3_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   localparam int LAST = NUM_LEVELS + 1;

   logic     valid [0:LAST];
   logic     load  [0:LAST+1];
   pipe_type data  [0:LAST-1];

   // a stage loads when empty or when the stage ahead moves
   assign load[LAST+1] = !rsp_stall;
   for (genvar s = 0; s <= LAST; s++) begin : g_load
      assign load[s] = !valid[s] || load[s+1];
   end

   assign req_stall = !load[0];

   hilb3_front u_front (
      .clock     (clock),
      .reset     (reset),
      .load      (load[0]),
      .valid_in  (req_valid),
      .req_in    (req_data),
      .valid_out (valid[0]),
      .data_out  (data[0])
   );

   for (genvar k = 1; k <= NUM_LEVELS; k++) begin : g_level
      localparam axis_type ENC_Q = axis_type'(1) << (AXIS_BITS - k);
      localparam axis_type DEC_Q = axis_type'(1) << k;

      hilb3_level u_level (
         .clock     (clock),
         .reset     (reset),
         .load      (load[k]),
         .enc_q     (ENC_Q),
         .dec_q     (DEC_Q),
         .valid_in  (valid[k-1]),
         .data_in   (data[k-1]),
         .valid_out (valid[k]),
         .data_out  (data[k])
      );
   end

   hilb3_back u_back (
      .clock     (clock),
      .reset     (reset),
      .load      (load[LAST]),
      .valid_in  (valid[LAST-1]),
      .data_in   (data[LAST-1]),
      .valid_out (valid[LAST]),
      .rsp_out   (rsp_data)
   );

   assign rsp_valid = valid[LAST];

   // an accepted beat always lands in the front stage
   a_accept_lands: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> valid[0])
      else $error("accepted request beat not captured");

   // input backs up only when every stage is full behind a stalled output
   a_stall_only_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (rsp_valid && rsp_stall && valid[0] && valid[LAST-1]))
      else $error("request stalled while pipeline has room");

   // a response carries either an index or coordinates, never both
   a_one_kind: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.index_out == '0 ||
                     (rsp_data.x_out == '0 && rsp_data.y_out == '0 &&
                      rsp_data.z_out == '0)))
      else $error("response mixes index and coordinate fields");

endmodule
